// ===== sv/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared types and constants of the glyph slot cache replacement unit.
// ----------------------------------------------------------------------------
package gsc_pkg;

	localparam int MAX_SLOTS   = 256;
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int HASH_W      = 31;
	localparam int DIV_CNT_W   = $clog2(HASH_W);
	localparam int HANDLE_W    = 32;
	localparam int STAMP_W     = 32;
	localparam int CFG_IDX_W   = 2;

	localparam logic [STAMP_W-1:0] STAMP_LIMIT = 32'd99999999;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_CLEAR  = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEARCH_MODE  = 2'd0,
		REG_SLOTS_IN_USE = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HASH,
		ST_SCAN,
		ST_LAST,
		ST_FETCH,
		ST_WRITE
	} gsc_state_t;

endpackage

// ===== sv/gsc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// gsc_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module gsc_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [gsc_pkg::HASH_W-1:0]  dividend,
	input  logic [gsc_pkg::CNT_W-1:0]   divisor,
	output logic                        done,
	output logic [gsc_pkg::SLOT_W-1:0]  remainder
);
	import gsc_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [HASH_W-1:0]    quot_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [CNT_W-1:0]     trial;
	logic [CNT_W-1:0]     diff;
	logic [SLOT_W-1:0]    rem_d;
	logic                 last_step;

	assign trial     = {rem_q, quot_q[HASH_W-1]};
	assign diff      = trial - divisor;
	assign rem_d     = (trial >= divisor) ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
	assign last_step = (cnt_q == DIV_CNT_W'(HASH_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last_step;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (run_q) begin
			quot_q <= {quot_q[HASH_W-2:0], 1'b0};
			rem_q  <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== sv/glyph_slot_cache_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// glyph_slot_cache_replacement_unit
// Hashed glyph slot table with direct or empty/oldest-entry replacement.
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// request   in         start / busy     req_type, code, entry_handle
// result    out        done (1 cycle)   slot, replaced, replaced_handle, freed_count
// config    in         cfg_we           cfg_index, cfg_data
//
// Insert: bit-serial remainder (31 steps and a handoff), then in search mode
// with the home slot occupied up to n slot visits at one per cycle through the
// stamp memory port, then steps to pick, fetch and write.
// Clear: one occupancy bit per cycle over all 256 slots.
// Done shows in the first idle cycle after the last busy one.
// Reset empties the table at once through per-slot occupancy flops.
// The result receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module glyph_slot_cache_replacement_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [31:0]                   code,
	input  logic [gsc_pkg::HANDLE_W-1:0]  entry_handle,
	output logic                          done,
	output logic [gsc_pkg::SLOT_W-1:0]    slot,
	output logic                          replaced,
	output logic [gsc_pkg::HANDLE_W-1:0]  replaced_handle,
	output logic [gsc_pkg::CNT_W-1:0]     freed_count,
	input  logic                          cfg_we,
	input  logic [gsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gsc_pkg::CNT_W-1:0]     cfg_data
);
	import gsc_pkg::*;

	gsc_state_t state_q, state_d;

	logic                  search_q;
	logic [CNT_W-1:0]      slots_q;
	logic [STAMP_W-1:0]    counter_q;
	logic [MAX_SLOTS-1:0]  occ_q;
	logic                  done_q;
	logic                  pend_q;

	logic [HANDLE_W-1:0]   handle_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [SLOT_W-1:0]     idx_s1;
	logic [SLOT_W-1:0]     home_q;
	logic [SLOT_W-1:0]     chosen_q;
	logic [SLOT_W-1:0]     best_idx_q;
	logic [STAMP_W-1:0]    best_q;
	logic [CNT_W-1:0]      freed_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  replaced_q;
	logic [HANDLE_W-1:0]   rhandle_q;
	logic [CNT_W-1:0]      fcount_q;

	logic [HANDLE_W-1:0]   handle_mem [MAX_SLOTS];
	logic [STAMP_W-1:0]    stamp_mem  [MAX_SLOTS];
	logic [HANDLE_W-1:0]   handle_rd_s1;
	logic [STAMP_W-1:0]    stamp_rd_s1;

	logic [CNT_W-1:0]      n_act;
	logic [SLOT_W-1:0]     last_idx;
	logic                  div_go;
	logic                  div_done;
	logic [SLOT_W-1:0]     div_rem;
	logic                  accept;
	logic                  cmp_hit;
	logic [SLOT_W-1:0]     last_pick;
	logic [CNT_W-1:0]      freed_next;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		if (slots_q == '0) begin
			n_act = CNT_W'(1);
		end else if (slots_q > CNT_W'(MAX_SLOTS)) begin
			n_act = CNT_W'(MAX_SLOTS);
		end else begin
			n_act = slots_q;
		end
	end

	assign last_idx   = SLOT_W'(n_act - 1'b1);
	assign cmp_hit    = pend_q && (stamp_rd_s1 < best_q);
	assign freed_next = freed_q + CNT_W'(occ_q[idx_q]);

	always_comb begin
		if (cmp_hit) begin
			last_pick = idx_s1;
		end else if (best_q != STAMP_LIMIT) begin
			last_pick = best_idx_q;
		end else begin
			last_pick = home_q;
		end
	end

	gsc_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (code[HASH_W-1:0]),
		.divisor   (n_act),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_t'(req_type) == REQ_CLEAR) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_HASH;
						div_go  = 1'b1;
					end
				end
			end
			ST_CLEAR: begin
				if (idx_q == SLOT_W'(MAX_SLOTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_HASH: begin
				if (div_done) begin
					state_d = (search_q && occ_q[div_rem]) ? ST_SCAN : ST_FETCH;
				end
			end
			ST_SCAN: begin
				if (!occ_q[idx_q]) begin
					state_d = ST_FETCH;
				end else if (idx_q == last_idx) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST:  state_d = ST_FETCH;
			ST_FETCH: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			search_q  <= 1'b0;
			slots_q   <= CNT_W'(MAX_SLOTS);
			counter_q <= '0;
			occ_q     <= '0;
			done_q    <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == ST_CLEAR) || (state_q == ST_WRITE)) &&
			           (state_d == ST_IDLE);
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SEARCH_MODE:  search_q <= cfg_data[0];
					REG_SLOTS_IN_USE: slots_q  <= cfg_data;
					default: ;
				endcase
			end
			pend_q <= (state_q == ST_SCAN) && occ_q[idx_q];
			if (state_q == ST_CLEAR) begin
				occ_q[idx_q] <= 1'b0;
			end
			if (state_q == ST_WRITE) begin
				occ_q[chosen_q] <= (handle_q != '0);
				counter_q       <= counter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			handle_q <= entry_handle;
			idx_q    <= '0;
			freed_q  <= '0;
		end
		case (state_q)
			ST_CLEAR: begin
				idx_q   <= idx_q + 1'b1;
				freed_q <= freed_next;
				if (state_d == ST_IDLE) begin
					slot_q     <= '0;
					replaced_q <= 1'b0;
					rhandle_q  <= '0;
					fcount_q   <= freed_next;
				end
			end
			ST_HASH: begin
				if (div_done) begin
					home_q   <= div_rem;
					chosen_q <= div_rem;
					idx_q    <= '0;
					best_q   <= STAMP_LIMIT;
				end
			end
			ST_SCAN: begin
				if (cmp_hit) begin
					best_q     <= stamp_rd_s1;
					best_idx_q <= idx_s1;
				end
				idx_s1 <= idx_q;
				if (!occ_q[idx_q]) begin
					chosen_q <= idx_q;
				end else if (idx_q != last_idx) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_LAST: begin
				chosen_q <= last_pick;
			end
			ST_WRITE: begin
				slot_q     <= chosen_q;
				replaced_q <= occ_q[chosen_q];
				rhandle_q  <= occ_q[chosen_q] ? handle_rd_s1 : '0;
				fcount_q   <= '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			handle_mem[chosen_q] <= handle_q;
		end
		handle_rd_s1 <= handle_mem[chosen_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			stamp_mem[chosen_q] <= counter_q;
		end
		stamp_rd_s1 <= stamp_mem[idx_q];
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign slot            = slot_q;
	assign replaced        = replaced_q;
	assign replaced_handle = rhandle_q;
	assign freed_count     = fcount_q;

endmodule

// ===== sv/gsc_checker.sv =====
// ----------------------------------------------------------------------------
// gsc_checker
// Port-level checks of the glyph slot cache replacement unit.
// ----------------------------------------------------------------------------
module gsc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          done,
	input  logic [gsc_pkg::SLOT_W-1:0]    slot,
	input  logic                          replaced,
	input  logic [gsc_pkg::HANDLE_W-1:0]  replaced_handle,
	input  logic [gsc_pkg::CNT_W-1:0]     freed_count
);
	import gsc_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result");

	a_replaced_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (replaced == (replaced_handle != '0)))
		else $error("replaced flag disagrees with evicted handle");

	a_clear_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (freed_count != '0) |-> (slot == '0) && !replaced)
		else $error("clear result carries insert fields");

endmodule

bind glyph_slot_cache_replacement_unit gsc_checker u_gsc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.slot            (slot),
	.replaced        (replaced),
	.replaced_handle (replaced_handle),
	.freed_count     (freed_count)
);
